>>> hw/rtl/pic_pkg.sv
// Shared types and constants for the priority interrupt controller.
// Used by pic_prio_enc, pic_core and the priority_interrupt_controller top level.
`default_nettype none

package pic_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned LINE_W      = 6;   // line number inside the 64-line mask
  localparam int unsigned IRQ_LINE_W  = 7;   // line number as it arrives on a request
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned SEL_W       = 3;
  localparam int unsigned STRIDE_LOG2 = 3;   // vector table entries are 8 bytes apart
  localparam int unsigned GRP_W       = 3;   // eight groups of eight lines
  localparam int unsigned GRP_SIZE    = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ       = 3'd0,
    REQ_WRITE      = 3'd1,
    REQ_RAISE      = 3'd2,
    REQ_CLEAR      = 3'd3,
    REQ_SERVE      = 3'd4,
    REQ_FETCH_FAIL = 3'd5
  } req_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_PENDING = 3'd0,
    SEL_ENABLED = 3'd1,
    SEL_CONTROL = 3'd2,
    SEL_VECTOR  = 3'd3,
    SEL_CURRENT = 3'd4,
    SEL_ACK     = 3'd5
  } sel_e;

  // One staged transaction.
  typedef struct packed {
    logic [REQ_W-1:0]      req;
    logic [SEL_W-1:0]      sel;
    logic [DATA_W-1:0]     wdata;
    logic [IRQ_LINE_W-1:0] line;
    logic                  in_irq;
    logic                  at_iret;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              served;
    logic [LINE_W-1:0] sline;
    logic [DATA_W-1:0] vaddr;
  } result_t;

  // Priority encoder answer.
  typedef struct packed {
    logic              found;
    logic [LINE_W-1:0] line;
  } pick_t;

endpackage

`default_nettype wire

>>> hw/rtl/priority_interrupt_controller.sv
// Top level of the fixed-priority interrupt controller: input register, core, result register.
// Depends on pic_pkg and pic_core (which holds pic_prio_enc).
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one request per transaction: a bus
//   read or write of a register, a raise or clear of one line, a serve check, or a
//   vector-fetch-failed notice. Output channel (out_valid_o / out_stall_i) returns
//   exactly one result transaction per request, in order.
//   Path: a taken request sits in the input register; when it advances it is decoded
//   and applied to the register state, and its result lands in the result register
//   and is shown on the output ports until taken.
//   Throughput: one transaction per cycle while the receiver does not stall. The only
//   work per item is a two-level 8x8 priority encoder and one 64-bit add for the vector
//   address, all combinational between the input register and the result register.
//   Each request sees the state left by the request before it, so back-to-back serve
//   checks never pick the same line twice.
//   Reset (rst_ni low, asynchronous) clears all masks, control, vector base and the
//   line in service, and empties both stages. No clearing pass follows.
//   Receiver stall: the result register holds its transaction; the next request waits
//   in the input register, and in_stall_o rises only when both stages are full.
`default_nettype none

module priority_interrupt_controller #(
  parameter int unsigned LAST_LINE = 63
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pic_pkg::REQ_W-1:0]         req_type_i,
  input  logic [pic_pkg::SEL_W-1:0]         reg_sel_i,
  input  logic [pic_pkg::DATA_W-1:0]        write_data_i,
  input  logic [pic_pkg::IRQ_LINE_W-1:0]    irq_line_i,
  input  logic                              core_in_interrupt_i,
  input  logic                              core_at_iret_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pic_pkg::DATA_W-1:0]        read_data_o,
  output logic                              served_o,
  output logic [pic_pkg::LINE_W-1:0]        served_line_o,
  output logic [pic_pkg::DATA_W-1:0]        vector_address_o
);
  import pic_pkg::*;

  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  logic    out_valid_q, out_valid_d;
  result_t result_q;
  result_t result_d;
  logic    in_accept;
  logic    fire;

  // Advance the staged request when the result register is empty or being drained.
  assign fire       = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~fire;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign in_valid_d  = in_accept | (in_valid_q & ~fire);
  assign out_valid_d = fire | (out_valid_q & out_stall_i);

  pic_core #(
    .LAST_LINE (LAST_LINE)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .result_o (result_d)
  );

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: capture on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.req     <= req_type_i;
      item_q.sel     <= reg_sel_i;
      item_q.wdata   <= write_data_i;
      item_q.line    <= irq_line_i;
      item_q.in_irq  <= core_in_interrupt_i;
      item_q.at_iret <= core_at_iret_i;
    end
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = result_q.rdata;
  assign served_o         = result_q.served;
  assign served_line_o    = result_q.sline;
  assign vector_address_o = result_q.vaddr;

endmodule

`default_nettype wire

>>> hw/rtl/pic_prio_enc.sv
// Lowest-set-bit priority encoder over the 64-line active mask.
// Depends on pic_pkg for widths and the pick_t result type.
`default_nettype none

module pic_prio_enc (
  input  logic [pic_pkg::DATA_W-1:0] active_i,
  output pic_pkg::pick_t             pick_o
);
  import pic_pkg::*;

  logic [GRP_SIZE-1:0] grp_any;
  logic [GRP_W-1:0]    grp;
  logic [GRP_SIZE-1:0] grp_bits;
  logic [GRP_W-1:0]    bit_idx;

  // Two levels of eight: first the lowest busy group, then the lowest bit in it.
  always_comb begin
    grp_any = '0;
    for (int g = 0; g < GRP_SIZE; g++) begin
      grp_any[g] = |active_i[g*GRP_SIZE +: GRP_SIZE];
    end
    grp = '0;
    for (int g = GRP_SIZE - 1; g >= 0; g--) begin
      if (grp_any[g]) grp = GRP_W'(g);
    end
    grp_bits = active_i[{grp, 3'b000} +: GRP_SIZE];
    bit_idx = '0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) bit_idx = GRP_W'(b);
    end
  end

  assign pick_o.found = |grp_any;
  assign pick_o.line  = {grp, bit_idx};

endmodule

`default_nettype wire

>>> hw/rtl/pic_core.sv
// Register file and request decode of the interrupt controller.
// Depends on pic_pkg and pic_prio_enc; updates state when the top level fires a transaction.
`default_nettype none

module pic_core #(
  parameter int unsigned LAST_LINE = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  pic_pkg::item_t   item_i,
  output pic_pkg::result_t result_o
);
  import pic_pkg::*;

  localparam logic [DATA_W-1:0] LINE_MASK = {DATA_W{1'b1}} >> (DATA_W - 1 - LAST_LINE);

  logic [DATA_W-1:0] pending_q, pending_d;
  logic [DATA_W-1:0] enable_q, enable_d;
  logic [DATA_W-1:0] control_q, control_d;
  logic [DATA_W-1:0] vbase_q, vbase_d;
  logic              cur_valid_q, cur_valid_d;
  logic [LINE_W-1:0] cur_line_q, cur_line_d;

  logic [DATA_W-1:0] active;
  pick_t             pick;
  logic              line_ok;
  logic [DATA_W-1:0] line_bit;
  logic              take;

  assign active = pending_q & enable_q & LINE_MASK;

  pic_prio_enc u_prio_enc (
    .active_i (active),
    .pick_o   (pick)
  );

  assign line_ok  = item_i.line <= IRQ_LINE_W'(LAST_LINE);
  assign line_bit = DATA_W'(1) << item_i.line[LINE_W-1:0];
  assign take     = control_q[0] & ~item_i.in_irq & ~item_i.at_iret & pick.found;

  always_comb begin
    pending_d   = pending_q;
    enable_d    = enable_q;
    control_d   = control_q;
    vbase_d     = vbase_q;
    cur_valid_d = cur_valid_q;
    cur_line_d  = cur_line_q;
    result_o    = '0;
    unique case (req_e'(item_i.req))
      REQ_READ: begin
        unique case (sel_e'(item_i.sel))
          SEL_PENDING: result_o.rdata = pending_q;
          SEL_ENABLED: result_o.rdata = enable_q;
          SEL_CONTROL: result_o.rdata = control_q;
          SEL_VECTOR:  result_o.rdata = vbase_q;
          SEL_CURRENT: result_o.rdata = cur_valid_q ? DATA_W'(cur_line_q) : '1;
          default:     result_o.rdata = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (sel_e'(item_i.sel))
          SEL_PENDING: pending_d = pending_q & ~item_i.wdata;
          SEL_ENABLED: enable_d  = item_i.wdata;
          SEL_CONTROL: control_d = item_i.wdata;
          SEL_VECTOR:  vbase_d   = item_i.wdata;
          SEL_ACK: begin
            if (cur_valid_q && item_i.wdata == DATA_W'(cur_line_q)) cur_valid_d = 1'b0;
          end
          default: ;
        endcase
      end
      REQ_RAISE: begin
        if (line_ok) pending_d = pending_q | line_bit;
      end
      REQ_CLEAR: begin
        if (line_ok) pending_d = pending_q & ~line_bit;
      end
      REQ_SERVE: begin
        if (take) begin
          cur_valid_d     = 1'b1;
          cur_line_d      = pick.line;
          pending_d       = pending_q & ~(DATA_W'(1) << pick.line);
          result_o.served = 1'b1;
          result_o.sline  = pick.line;
          result_o.vaddr  = vbase_q + DATA_W'({pick.line, {STRIDE_LOG2{1'b0}}});
        end
      end
      REQ_FETCH_FAIL: cur_valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      enable_q    <= '0;
      control_q   <= '0;
      vbase_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_line_q  <= '0;
    end else if (fire_i) begin
      pending_q   <= pending_d;
      enable_q    <= enable_d;
      control_q   <= control_d;
      vbase_q     <= vbase_d;
      cur_valid_q <= cur_valid_d;
      cur_line_q  <= cur_line_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pic_checker.sv
// Port-level checker for priority_interrupt_controller, bound to the top level below.
// Sees only the top-level ports; depends on pic_pkg for widths.
`default_nettype none

module pic_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [pic_pkg::REQ_W-1:0]      req_type_i,
  input logic [pic_pkg::SEL_W-1:0]      reg_sel_i,
  input logic [pic_pkg::DATA_W-1:0]     write_data_i,
  input logic [pic_pkg::IRQ_LINE_W-1:0] irq_line_i,
  input logic                           core_in_interrupt_i,
  input logic                           core_at_iret_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [pic_pkg::DATA_W-1:0]     read_data_o,
  input logic                           served_o,
  input logic [pic_pkg::LINE_W-1:0]     served_line_o,
  input logic [pic_pkg::DATA_W-1:0]     vector_address_o
);

  // Input backpressure only comes from a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("in_stall_o raised without a stalled result");

  // A stalled request holds until taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(req_type_i) && $stable(reg_sel_i) &&
       $stable(write_data_i) && $stable(irq_line_i) &&
       $stable(core_in_interrupt_i) && $stable(core_at_iret_i)))
    else $error("stalled request changed");

  // A result without a taken interrupt carries no line and no vector.
  a_idle_serve_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !served_o) |-> (served_line_o == '0 && vector_address_o == '0))
    else $error("served_line/vector_address nonzero while not served");

  // A taken interrupt comes from a serve check, never from a bus read.
  a_serve_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && served_o) |-> (read_data_o == '0))
    else $error("read_data nonzero on a served result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(read_data_o) && $stable(served_o) &&
       $stable(served_line_o) && $stable(vector_address_o)))
    else $error("stalled result changed");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (.*);

`default_nettype wire

>>> tb/sv/tb_priority_interrupt_controller.sv
// Self-checking testbench for the 64-line priority interrupt controller.
// Needs pic_pkg and the priority_interrupt_controller RTL; a scoreboard class predicts every
// result transaction and checks the output channel against it in order.
`timescale 1ns / 100ps

module tb_priority_interrupt_controller;
  import pic_pkg::*;

  localparam int LAST_LINE    = 63;
  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction before giving up
  localparam int MAX_REPORTS  = 20;

  // Scoreboard: mirror of the register state plus the queue of results still owed.
  class pic_scoreboard;
    logic [DATA_W-1:0] pend_q, ena_q, ctrl_q, vbase_q;
    bit                cur_valid;
    logic [LINE_W-1:0] cur_line;
    result_t           awaited[$];
    int unsigned       errors, checked, taken, noted;

    function new();
      pend_q    = '0;
      ena_q     = '0;
      ctrl_q    = '0;
      vbase_q   = '0;
      cur_valid = 1'b0;
      cur_line  = '0;
      errors    = 0;
      checked   = 0;
      taken     = 0;
      noted     = 0;
    endfunction

    // Apply one accepted request to the mirror and queue the result it owes.
    function void note_request(item_t it);
      result_t           r;
      logic [DATA_W-1:0] active;
      int                hit;
      r   = '0;
      hit = -1;
      noted++;
      case (it.req)
        REQ_READ: begin
          case (it.sel)
            SEL_PENDING: r.rdata = pend_q;
            SEL_ENABLED: r.rdata = ena_q;
            SEL_CONTROL: r.rdata = ctrl_q;
            SEL_VECTOR:  r.rdata = vbase_q;
            SEL_CURRENT: r.rdata = cur_valid ? {{(DATA_W-LINE_W){1'b0}}, cur_line} : '1;
            default:     r.rdata = '0;
          endcase
        end
        REQ_WRITE: begin
          case (it.sel)
            SEL_PENDING: pend_q  = pend_q & ~it.wdata;
            SEL_ENABLED: ena_q   = it.wdata;
            SEL_CONTROL: ctrl_q  = it.wdata;
            SEL_VECTOR:  vbase_q = it.wdata;
            SEL_ACK: begin
              // ack only drops the line in service on a full-width match
              if (cur_valid && it.wdata == {{(DATA_W-LINE_W){1'b0}}, cur_line})
                cur_valid = 1'b0;
            end
            default: ;
          endcase
        end
        REQ_RAISE: begin
          if (it.line <= LAST_LINE) pend_q[it.line[LINE_W-1:0]] = 1'b1;
        end
        REQ_CLEAR: begin
          if (it.line <= LAST_LINE) pend_q[it.line[LINE_W-1:0]] = 1'b0;
        end
        REQ_SERVE: begin
          active = pend_q & ena_q;
          if (ctrl_q[0] && !it.in_irq && !it.at_iret) begin
            for (int i = LAST_LINE; i >= 0; i--)
              if (active[i]) hit = i;
          end
          if (hit >= 0) begin
            cur_valid    = 1'b1;
            cur_line     = hit[LINE_W-1:0];
            pend_q[hit]  = 1'b0;
            r.served     = 1'b1;
            r.sline      = hit[LINE_W-1:0];
            r.vaddr      = vbase_q + (DATA_W'(hit) << STRIDE_LOG2);
            taken++;
          end
        end
        REQ_FETCH_FAIL: cur_valid = 1'b0;
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_field(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) report(what, want, got);
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report("unexpected result, read_data", '0, got.rdata);
        return;
      end
      want = awaited.pop_front();
      checked++;
      check_field("read_data", want.rdata, got.rdata);
      check_field("served", DATA_W'(want.served), DATA_W'(got.served));
      check_field("served_line", DATA_W'(want.sline), DATA_W'(got.sline));
      check_field("vector_address", want.vaddr, got.vaddr);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      req_type = '0;
  logic [SEL_W-1:0]      reg_sel = '0;
  logic [DATA_W-1:0]     write_data = '0;
  logic [IRQ_LINE_W-1:0] irq_line = '0;
  logic                  core_in_irq = 1'b0;
  logic                  core_at_iret = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     read_data;
  logic                  served;
  logic [LINE_W-1:0]     served_line;
  logic [DATA_W-1:0]     vector_address;

  pic_scoreboard sb = new();

  priority_interrupt_controller #(
    .LAST_LINE(LAST_LINE)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .req_type_i         (req_type),
    .reg_sel_i          (reg_sel),
    .write_data_i       (write_data),
    .irq_line_i         (irq_line),
    .core_in_interrupt_i(core_in_irq),
    .core_at_iret_i     (core_at_iret),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .read_data_o        (read_data),
    .served_o           (served),
    .served_line_o      (served_line),
    .vector_address_o   (vector_address)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sample both channels at the rising edge. Check the output first: a result taken at
  // this edge can never belong to the request taken at the same edge.
  always @(posedge clk_i) begin : monitor
    item_t   it;
    result_t r;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        r.rdata  = read_data;
        r.served = served;
        r.sline  = served_line;
        r.vaddr  = vector_address;
        sb.check_result(r);
      end
      if (in_valid && !in_stall) begin
        it.req     = req_type;
        it.sel     = reg_sel;
        it.wdata   = write_data;
        it.line    = irq_line;
        it.in_irq  = core_in_irq;
        it.at_iret = core_at_iret;
        sb.note_request(it);
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up into its input,
  // and a stretch with no stalls at all.
  initial begin : receiver
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 300 && cyc < 360)
        out_stall <= 1'b1;
      else if (cyc >= 900 && cyc < 1200)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < 15);
    end
  end

  // Give up when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("priority_interrupt_controller: mismatch");
    $finish;
  end

  // Offer one request from the falling edge on and hold it until taken.
  task automatic send_request(input item_t it, input bit may_idle);
    while (may_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    req_type     <= it.req;
    reg_sel      <= it.sel;
    write_data   <= it.wdata;
    irq_line     <= it.line;
    core_in_irq  <= it.in_irq;
    core_at_iret <= it.at_iret;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel,
                             input logic [DATA_W-1:0] data, input logic [IRQ_LINE_W-1:0] line,
                             input bit irq, input bit iret);
    item_t it;
    it.req     = req;
    it.sel     = sel;
    it.wdata   = data;
    it.line    = line;
    it.in_irq  = irq;
    it.at_iret = iret;
    send_request(it, 1'b1);
  endtask

  // Mostly well-formed traffic: raises feed the pending mask, control usually keeps its
  // enable bit, acks often name the line in service. The rest is noise.
  function automatic item_t make_random_item();
    item_t it;
    int    pick;
    it.req     = REQ_W'($urandom_range(7));
    it.sel     = SEL_W'($urandom_range(7));
    it.wdata   = {$urandom, $urandom};
    it.line    = IRQ_LINE_W'($urandom_range(127));
    it.in_irq  = ($urandom_range(99) < 15);
    it.at_iret = ($urandom_range(99) < 15);
    pick = $urandom_range(99);
    if (pick < 3) begin
      it.req = REQ_W'($urandom_range(6, 7));
    end else if (pick < 28) begin
      it.req = REQ_RAISE;
      if ($urandom_range(9) != 0) it.line = IRQ_LINE_W'($urandom_range(LAST_LINE));
    end else if (pick < 36) begin
      it.req = REQ_CLEAR;
      if ($urandom_range(9) != 0) it.line = IRQ_LINE_W'($urandom_range(LAST_LINE));
    end else if (pick < 58) begin
      it.req = REQ_SERVE;
    end else if (pick < 73) begin
      it.req = REQ_READ;
    end else if (pick < 88) begin
      it.req = REQ_WRITE;
      case (it.sel)
        SEL_CONTROL: if ($urandom_range(9) != 0) it.wdata[0] = 1'b1;
        SEL_ENABLED: if ($urandom_range(3) == 0) it.wdata = '1;
        SEL_PENDING: if ($urandom_range(1) == 0) it.wdata = DATA_W'(1) << $urandom_range(63);
        SEL_ACK:     if ($urandom_range(1) == 0) it.wdata = DATA_W'($urandom_range(63));
        default: ;
      endcase
    end else if (pick < 94) begin
      it.req = REQ_FETCH_FAIL;
    end else begin
      it.req   = REQ_WRITE;
      it.sel   = SEL_ACK;
      it.wdata = {{(DATA_W-LINE_W){1'b0}}, sb.cur_line};
    end
    return it;
  endfunction

  task automatic run_directed();
    // registers straight out of reset, none in service
    send_fields(REQ_READ, SEL_CURRENT, '0, '0, 0, 0);
    send_fields(REQ_READ, 3'd7, '0, '0, 0, 0);
    // enable every line, arm the controller, put the table at the top so addresses wrap
    send_fields(REQ_WRITE, SEL_ENABLED, '1, '0, 0, 0);
    send_fields(REQ_WRITE, SEL_CONTROL, 64'd1, '0, 0, 0);
    send_fields(REQ_WRITE, SEL_VECTOR, '1, '0, 0, 0);
    // lowest and highest lines, then two numbers past the last line
    send_fields(REQ_RAISE, '0, '0, 7'd0, 0, 0);
    send_fields(REQ_RAISE, '0, '0, 7'd63, 0, 0);
    send_fields(REQ_RAISE, '0, '0, 7'd64, 0, 0);
    send_fields(REQ_RAISE, '0, '0, 7'd127, 0, 0);
    send_fields(REQ_READ, SEL_PENDING, '0, '0, 0, 0);
    // core busy in a handler, then at interrupt return: nothing taken
    send_fields(REQ_SERVE, '0, '0, '0, 1, 0);
    send_fields(REQ_SERVE, '0, '0, '0, 0, 1);
    send_fields(REQ_SERVE, '0, '0, '0, 0, 0);
    send_fields(REQ_READ, SEL_CURRENT, '0, '0, 0, 0);
    // ack naming the wrong line keeps the line in service
    send_fields(REQ_WRITE, SEL_ACK, 64'd1, '0, 0, 0);
    // serve while in service replaces the current line
    send_fields(REQ_SERVE, '0, '0, '0, 0, 0);
    send_fields(REQ_WRITE, SEL_ACK, 64'd63, '0, 0, 0);
    send_fields(REQ_READ, SEL_CURRENT, '0, '0, 0, 0);
    // nothing pending
    send_fields(REQ_SERVE, '0, '0, '0, 0, 0);
    // controller disabled with a line pending
    send_fields(REQ_RAISE, '0, '0, 7'd5, 0, 0);
    send_fields(REQ_WRITE, SEL_CONTROL, 64'hFFFF_FFFF_FFFF_FFFE, '0, 0, 0);
    send_fields(REQ_SERVE, '0, '0, '0, 0, 0);
    // writes to the read-only and unmapped selectors, then write-one-to-clear
    send_fields(REQ_WRITE, SEL_CURRENT, '0, '0, 0, 0);
    send_fields(REQ_WRITE, 3'd6, '1, '0, 0, 0);
    send_fields(REQ_WRITE, SEL_PENDING, '1, '0, 0, 0);
    send_fields(REQ_FETCH_FAIL, '0, '0, '0, 0, 0);
    send_fields(3'd6, SEL_PENDING, '1, 7'd1, 1, 1);
    send_fields(3'd7, SEL_PENDING, '1, 7'd1, 1, 1);
  endtask

  initial begin : stimulus
    // hold reset, then release it between edges
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_request(make_random_item(), !(n >= 400 && n < 650));
    in_valid <= 1'b0;

    // drain: every owed result has to come back
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("Ran %0d requests through the controller, checked %0d results, %0d interrupts taken.",
             sb.noted, sb.checked, sb.taken);
    $display("Errors found: %0d", sb.errors);
    if (sb.errors == 0)
      $display("priority_interrupt_controller: match");
    else
      $display("priority_interrupt_controller: mismatch");
    $finish;
  end

endmodule
